FILE: design/tlbnp_pkg.sv
// Shared types, constants and bit-search functions for the two-level bitmap.
`default_nettype none
package tlbnp_pkg;

	localparam int WORD_BITS_DEF  = 64;
	localparam int WORD_COUNT_DEF = 64;
	localparam int IDX_W          = 12;
	localparam int MAX_W          = 64;
	localparam int POS_W          = 6;
	localparam int DIV_SHIFT      = 24;

	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_NEXT  = 2'd2,
		OP_PREV  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_FETCH
	} state_t;

	// index of the lowest set bit, 0 for an all-zero word
	function automatic logic [POS_W-1:0] lowest_one(input logic [MAX_W-1:0] v);
		logic [POS_W-1:0] n;
		n = '0;
		for (int i = MAX_W - 1; i >= 0; i--) begin
			if (v[i])
				n = POS_W'(i);
		end
		return n;
	endfunction

	// index of the highest set bit, 0 for an all-zero word
	function automatic logic [POS_W-1:0] highest_one(input logic [MAX_W-1:0] v);
		logic [POS_W-1:0] n;
		n = '0;
		for (int i = 0; i < MAX_W; i++) begin
			if (v[i])
				n = POS_W'(i);
		end
		return n;
	endfunction

endpackage
`default_nettype wire

FILE: design/tlbnp_word_div.sv
// Splits a bit index into its word number by reciprocal multiplication, clamping past capacity.
`default_nettype none
module tlbnp_word_div #(
	parameter int WORD_BITS  = tlbnp_pkg::WORD_BITS_DEF,
	parameter int WORD_COUNT = tlbnp_pkg::WORD_COUNT_DEF
) (
	input  wire logic [tlbnp_pkg::IDX_W-1:0]      bit_index,
	output logic      [tlbnp_pkg::IDX_W-1:0]      idx_clamp,
	output logic                                  in_range,
	output logic      [$clog2(WORD_COUNT)-1:0]    word_sel
);
	import tlbnp_pkg::*;

	localparam int WW     = $clog2(WORD_COUNT);
	localparam int CAP    = WORD_BITS * WORD_COUNT;
	localparam int RECIP  = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
	localparam int PROD_W = IDX_W + DIV_SHIFT - 2;

	logic [PROD_W-1:0] prod;

	// ceil(2^24 / WORD_BITS) is exact for every 12-bit index
	always_comb begin
		in_range  = ({1'b0, bit_index} < (IDX_W + 1)'(CAP));
		idx_clamp = in_range ? bit_index : IDX_W'(CAP - 1);
		prod      = PROD_W'(idx_clamp) * PROD_W'(RECIP);
		word_sel  = prod[DIV_SHIFT +: WW];
	end

endmodule
`default_nettype wire

FILE: design/tlbnp_leaf_mem.sv
// Leaf word memory with registered read and per-word valid bits.
`default_nettype none
module tlbnp_leaf_mem #(
	parameter int WORD_BITS  = tlbnp_pkg::WORD_BITS_DEF,
	parameter int WORD_COUNT = tlbnp_pkg::WORD_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          we,
	input  wire logic [$clog2(WORD_COUNT)-1:0] waddr,
	input  wire logic [WORD_BITS-1:0]          wdata,
	input  wire logic [$clog2(WORD_COUNT)-1:0] raddr,
	output logic      [WORD_BITS-1:0]          rdata
);
	import tlbnp_pkg::*;

	logic [WORD_BITS-1:0]  mem [WORD_COUNT];
	logic [WORD_COUNT-1:0] vld_q;
	logic [WORD_BITS-1:0]  rd_q;
	logic                  rd_vld_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	// a word never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we)
				vld_q[waddr] <= 1'b1;
			rd_vld_q <= vld_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

FILE: design/two_level_bitmap_next_prev_set.sv
// Two-level occupancy bitmap: leaf memory plus summary word, with next/prev set-bit search.
// Set/clear: accepted, then a read-modify-write in ST_LOOK; a new request only after busy drops.
// Search: done strobes after ST_LOOK when the start word holds a hit, after ST_FETCH
// when the summary picks another word (second leaf memory read); next word after busy drops.
// Rate is set by the leaf memory's single read port: one read per cycle.
// Reset clears the summary and the leaf valid bits at once; the bitmap reads all zero.
`default_nettype none
module two_level_bitmap_next_prev_set #(
	parameter int WORD_BITS  = tlbnp_pkg::WORD_BITS_DEF,
	parameter int WORD_COUNT = tlbnp_pkg::WORD_COUNT_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  operation,
	input  wire logic [tlbnp_pkg::IDX_W-1:0] bit_index,
	output logic                             done,
	output logic                             found,
	output logic      [tlbnp_pkg::IDX_W-1:0] position
);
	import tlbnp_pkg::*;

	localparam int WW = $clog2(WORD_COUNT);
	localparam int BW = $clog2(WORD_BITS);
	localparam logic [IDX_W-1:0] WB12 = IDX_W'(WORD_BITS);

	state_t state_q, state_d;

	op_t                   op_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  in_range_q;
	logic [WW-1:0]         w_q, w_d;
	logic [WORD_COUNT-1:0] sum_q, sum_d;
	logic                  done_q, found_q;
	logic [IDX_W-1:0]      pos_q;

	logic [IDX_W-1:0]      div_idx;
	logic                  div_in_range;
	logic [WW-1:0]         div_word;

	logic                  mem_we;
	logic [WW-1:0]         rd_addr;
	logic [WORD_BITS-1:0]  word;
	logic [WORD_BITS-1:0]  new_word;

	logic [IDX_W-1:0]      off12;
	logic [BW-1:0]         bsel;
	logic [WORD_BITS-1:0]  bit_mask;
	logic [WORD_BITS-1:0]  v_masked;
	logic [WORD_COUNT-1:0] s_masked;
	logic [WW-1:0]         w2;
	logic [WORD_BITS-1:0]  sel_word;
	logic [BW-1:0]         bitpos;
	logic [IDX_W-1:0]      hit_pos;
	logic                  search_ok;

	logic                  res_valid, res_found;
	logic [IDX_W-1:0]      res_pos;

	tlbnp_word_div #(
		.WORD_BITS  (WORD_BITS),
		.WORD_COUNT (WORD_COUNT)
	) u_div (
		.bit_index (bit_index),
		.idx_clamp (div_idx),
		.in_range  (div_in_range),
		.word_sel  (div_word)
	);

	tlbnp_leaf_mem #(
		.WORD_BITS  (WORD_BITS),
		.WORD_COUNT (WORD_COUNT)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (w_q),
		.wdata  (new_word),
		.raddr  (rd_addr),
		.rdata  (word)
	);

	// datapath around the word just read
	always_comb begin
		off12    = idx_q - (IDX_W'(w_q) * WB12);
		bsel     = off12[BW-1:0];
		bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << bsel;
		new_word = (op_q == OP_SET) ? (word | bit_mask) : (word & ~bit_mask);
		if (op_q == OP_NEXT) begin
			v_masked = word & ({WORD_BITS{1'b1}} << bsel);
			s_masked = sum_q & (({WORD_COUNT{1'b1}} << w_q) << 1);
			w2       = WW'(lowest_one(MAX_W'(s_masked)));
		end else begin
			v_masked = word & ({WORD_BITS{1'b1}} >> (BW'(WORD_BITS - 1) - bsel));
			s_masked = sum_q & ~({WORD_COUNT{1'b1}} << w_q);
			w2       = WW'(highest_one(MAX_W'(s_masked)));
		end
		sel_word  = (state_q == ST_FETCH) ? word : v_masked;
		bitpos    = (op_q == OP_NEXT) ? BW'(lowest_one(MAX_W'(sel_word)))
		                              : BW'(highest_one(MAX_W'(sel_word)));
		hit_pos   = (IDX_W'(w_q) * WB12) + IDX_W'(bitpos);
		search_ok = in_range_q || (op_q == OP_PREV);
	end

	// next state and control
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		rd_addr   = div_word;
		w_d       = w_q;
		sum_d     = sum_q;
		res_valid = 1'b0;
		res_found = 1'b0;
		res_pos   = '0;
		case (state_q)
			ST_IDLE: begin
				if (start)
					state_d = ST_LOOK;
			end
			ST_LOOK: begin
				case (op_q)
					OP_SET, OP_CLEAR: begin
						if (in_range_q) begin
							mem_we     = 1'b1;
							sum_d[w_q] = |new_word;
						end
						state_d = ST_IDLE;
					end
					default: begin
						if (search_ok && (v_masked != '0)) begin
							res_valid = 1'b1;
							res_found = 1'b1;
							res_pos   = hit_pos;
							state_d   = ST_IDLE;
						end else if (search_ok && (s_masked != '0)) begin
							rd_addr = w2;
							w_d     = w2;
							state_d = ST_FETCH;
						end else begin
							res_valid = 1'b1;
							state_d   = ST_IDLE;
						end
					end
				endcase
			end
			ST_FETCH: begin
				res_valid = 1'b1;
				res_found = |word;
				res_pos   = (|word) ? hit_pos : '0;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			done_q <= 1'b0;
		end else begin
			sum_q  <= sum_d;
			done_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			op_q       <= op_t'(operation);
			idx_q      <= div_idx;
			in_range_q <= div_in_range;
			w_q        <= div_word;
		end else begin
			w_q <= w_d;
		end
		found_q <= res_found;
		pos_q   <= res_pos;
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign found    = found_q;
	assign position = pos_q;

endmodule
`default_nettype wire
